// ===== hdl/pot_pkg.sv =====
// Package for the priority ordered table: sizes, operation codes,
// entry and memory request types, controller states. No dependencies.
`default_nettype none

package pot_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SERVE  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // class sits above key so that packed compare gives table order
    typedef struct packed {
        logic [1:0]          cls;
        logic [KEY_BITS-1:0] key;
    } t_entry;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_entry            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_EV,
        ST_SRCH_RD,
        ST_SRCH_EV,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } t_state;

    function automatic logic entry_below(input t_entry a, input t_entry b);
        return a < b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pot_store.sv =====
// Entry memory of the priority ordered table: one write port, one read
// port with registered read data. Depends on pot_pkg.
`default_nettype none

module pot_store
    import pot_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_entry        o_rd_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/priority_ordered_table.sv =====
// Top level of the priority ordered table: command controller that keeps
// entries sorted by (class, key) in pot_store. Depends on pot_pkg, pot_store.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  request | start / busy           | i_operation, i_entry_key, i_class_level
//  result  | o_strobe (one cycle)   | o_operation_echo, o_key_echo, o_found_class,
//          |                        | o_hit, o_full_reject
//
// One request at a time; busy stays high from acceptance through the strobe.
// Insert: from the back, each entry not below the new one is shifted up one
// place, and the new entry is written where the scan stops or at the front.
// Serve/remove: entries are searched by key from the front and those after a
// hit are shifted down; a full-table reject or unused code goes to the strobe.
// Each scan step reads memory, then compares (insert, search) or writes (insert, shift).
// Synchronous active-low reset empties the table; no clearing pass is needed.
// The receiver cannot stall: the result is shown for exactly one cycle.
`default_nettype none

module priority_ordered_table
    import pot_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [15:0] i_entry_key,
    input  wire logic [1:0]  i_class_level,
    output logic             o_strobe,
    output logic [1:0]       o_operation_echo,
    output logic [15:0]      o_key_echo,
    output logic [1:0]       o_found_class,
    output logic             o_hit,
    output logic             o_full_reject
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_occ, n_occ;
    logic [1:0]          r_op, n_op;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [1:0]          r_cls, n_cls;
    logic [1:0]          r_found, n_found;
    logic                r_hit, n_hit;
    logic                r_reject, n_reject;

    t_mem_req mem_req;
    t_entry   rd_data;
    t_entry   new_entry;

    assign new_entry = '{cls: r_cls, key: r_key};

    pot_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_occ    <= '0;
            r_idx    <= '0;
            r_found  <= '0;
            r_hit    <= 1'b0;
            r_reject <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_idx    <= n_idx;
            r_found  <= n_found;
            r_hit    <= n_hit;
            r_reject <= n_reject;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_key <= n_key;
        r_cls <= n_cls;
    end

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_occ    = r_occ;
        n_op     = r_op;
        n_key    = r_key;
        n_cls    = r_cls;
        n_found  = r_found;
        n_hit    = r_hit;
        n_reject = r_reject;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op     = i_operation;
                    n_key    = KEY_BITS'(i_entry_key);
                    n_cls    = i_class_level;
                    n_found  = '0;
                    n_hit    = 1'b0;
                    n_reject = 1'b0;
                    if (i_operation == OP_INSERT) begin
                        if (r_occ == CNT_W'(TABLE_DEPTH)) begin
                            n_reject = 1'b1;
                            n_state  = ST_DONE;
                        end else begin
                            n_idx   = r_occ;
                            n_state = ST_INS_RD;
                        end
                    end else if (i_operation == OP_SERVE || i_operation == OP_REMOVE) begin
                        n_idx   = '0;
                        n_state = ST_SRCH_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_INS_RD: begin
                if (r_idx == '0) begin
                    n_occ   = CNT_W'(r_occ + 1'b1);
                    n_found = r_cls;
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_INS_EV;
                end
            end
            ST_INS_EV: begin
                if (entry_below(rd_data, new_entry)) begin
                    n_occ   = CNT_W'(r_occ + 1'b1);
                    n_found = r_cls;
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_idx   = CNT_W'(r_idx - 1'b1);
                    n_state = ST_INS_RD;
                end
            end
            ST_SRCH_RD: begin
                if (r_idx == r_occ) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SRCH_EV;
                end
            end
            ST_SRCH_EV: begin
                if (rd_data.key == r_key) begin
                    n_found = rd_data.cls;
                    n_hit   = 1'b1;
                    n_state = ST_SHIFT_RD;
                end else begin
                    n_idx   = CNT_W'(r_idx + 1'b1);
                    n_state = ST_SRCH_RD;
                end
            end
            ST_SHIFT_RD: begin
                if (CNT_W'(r_idx + 1'b1) == r_occ) begin
                    n_occ   = CNT_W'(r_occ - 1'b1);
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                n_idx   = CNT_W'(r_idx + 1'b1);
                n_state = ST_SHIFT_RD;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // memory requests and ports
    always_comb begin
        mem_req         = '0;
        mem_req.wr_addr = r_idx[ADDR_W-1:0];
        mem_req.wr_data = rd_data;
        mem_req.rd_addr = r_idx[ADDR_W-1:0];
        unique case (r_state)
            ST_INS_RD: begin
                if (r_idx == '0) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = new_entry;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ADDR_W'(r_idx - 1'b1);
                end
            end
            ST_INS_EV: begin
                mem_req.wr_en = 1'b1;
                if (entry_below(rd_data, new_entry)) begin
                    mem_req.wr_data = new_entry;
                end
            end
            ST_SRCH_RD: begin
                mem_req.rd_en = (r_idx != r_occ);
            end
            ST_SHIFT_RD: begin
                mem_req.rd_en   = (CNT_W'(r_idx + 1'b1) != r_occ);
                mem_req.rd_addr = ADDR_W'(r_idx + 1'b1);
            end
            ST_SHIFT_WR: begin
                mem_req.wr_en = 1'b1;
            end
            default: begin
                mem_req.wr_en = 1'b0;
            end
        endcase

        busy             = (r_state != ST_IDLE);
        o_strobe         = (r_state == ST_DONE);
        o_operation_echo = r_op;
        o_key_echo       = 16'(r_key);
        o_found_class    = r_found;
        o_hit            = r_hit;
        o_full_reject    = r_reject;
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(TABLE_DEPTH))
        else $error("occupancy above table depth");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_full_reject) |-> (!o_hit && o_found_class == 2'd0
            && o_operation_echo == OP_INSERT))
        else $error("full reject with hit or class");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ != $past(r_occ)) |-> (r_state == ST_DONE))
        else $error("occupancy changed outside request completion");

endmodule

`default_nettype wire
